// File: src/dosing_pump_duty_timer_core_assert.svh
// Assertion macros used by the checker in dpdt_checker.sv.
`ifndef DOSING_PUMP_DUTY_TIMER_CORE_ASSERT_SVH
`define DOSING_PUMP_DUTY_TIMER_CORE_ASSERT_SVH

// Check the consequent in the same cycle as the antecedent.
`define DPDT_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("dpdt check failed");

// Check the consequent in the cycle after the antecedent.
`define DPDT_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("dpdt check failed");

`endif

// File: src/dpdt_pkg.sv
`default_nettype none

package dpdt_pkg;

	// Request kinds
	typedef enum logic {
		REQ_TICK    = 1'b0,
		REQ_COMMAND = 1'b1
	} req_kind_t;

	// Held status
	typedef enum logic [1:0] {
		LVL_OK      = 2'd0,
		LVL_WARNING = 2'd1,
		LVL_ERROR   = 2'd2
	} health_level_t;

	typedef enum logic [1:0] {
		CODE_OK    = 2'd0,
		CODE_STALE = 2'd1,
		CODE_BELOW = 2'd2,
		CODE_ABOVE = 2'd3
	} fault_code_t;

	// Configuration register indexes
	typedef enum logic [1:0] {
		CFG_DOSING_PERIOD    = 2'd0,
		CFG_SHUTOFF_TIME     = 2'd1,
		CFG_DRIVE_ACTIVE_LOW = 2'd2
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int RATE_W     = 16;
	localparam int PERIOD_W   = 16;
	localparam int SHUTOFF_W  = 32;
	localparam int ONTIME_W   = 16;

	localparam logic [PERIOD_W-1:0]  PERIOD_RESET  = 16'd10000;
	localparam logic [SHUTOFF_W-1:0] SHUTOFF_RESET = 32'd60000;

	localparam logic [RATE_W-1:0] RATE_MIN = 16'd100;
	localparam logic [RATE_W-1:0] RATE_MAX = 16'd1000;

	// rate * period for an accepted rate (<= 1000) stays below 2^26
	localparam int PROD_W = 26;

	// x / 1000 = (x >> 3) / 125; the quotient by 125 is (y * RECIP_M) >> RECIP_SHIFT,
	// exact for every y below 2^23
	localparam int                PRE_SHIFT   = 3;
	localparam int                RECIP_W     = 24;
	localparam logic [RECIP_W-1:0] RECIP_M    = 24'd8589935;
	localparam int                RECIP_SHIFT = 30;

endpackage

`default_nettype wire

// File: src/dpdt_cfg_if.sv
`default_nettype none

interface dpdt_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [dpdt_pkg::CFG_IDX_W-1:0]  index;
	logic [dpdt_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: src/dpdt_req_if.sv
`default_nettype none

interface dpdt_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [dpdt_pkg::RATE_W-1:0]  rate_ml_per_hour;

	modport source (output valid, output req_type, output rate_ml_per_hour, input ready);
	modport sink (input valid, input req_type, input rate_ml_per_hour, output ready);
endinterface

`default_nettype wire

// File: src/dpdt_res_if.sv
`default_nettype none

interface dpdt_res_if;
	logic       valid;
	logic       ready;
	logic       drive_level;
	logic [1:0] health_level;
	logic [1:0] fault_code;

	modport source (output valid, output drive_level, output health_level,
		output fault_code, input ready);
	modport sink (input valid, input drive_level, input health_level,
		input fault_code, output ready);
endinterface

`default_nettype wire

// File: src/dosing_pump_duty_timer_core.sv
// Channel  Dir  Payload                                       Accepted when
// cfg      in   index, data                                   valid && ready (ready always 1)
// req      in   req_type, rate_ml_per_hour                    valid && ready
// res      out  drive_level, health_level, fault_code         valid && ready
//
// One result per request, through the input stage and then the output register.
// Throughput is one request per cycle unless res stalls: an input stage and an
// output register, each freed as soon as the next stage takes its contents.
// The on-time multiply sits before the input stage, the divide by 1000 after it.
// arst_n clears the timers, the status and both stages at once.
// A stalled res holds its payload; req stays ready while the input stage can drain.
`default_nettype none

module dosing_pump_duty_timer_core #(
	parameter int TIME_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	dpdt_cfg_if.sink   cfg,
	dpdt_req_if.sink   req,
	dpdt_res_if.source res
);
	localparam int CMP_W = (TIME_BITS > dpdt_pkg::SHUTOFF_W) ? TIME_BITS : dpdt_pkg::SHUTOFF_W;

	// configuration
	logic [dpdt_pkg::PERIOD_W-1:0]  dosing_period_q;
	logic [dpdt_pkg::SHUTOFF_W-1:0] shutoff_time_q;
	logic                           drive_active_low_q;

	// input stage
	logic                              valid_s1;
	dpdt_pkg::req_kind_t               kind_s1;
	logic [dpdt_pkg::RATE_W-1:0]       rate_s1;
	logic [dpdt_pkg::PROD_W-1:0]       prod_s1;

	// timer state
	logic [TIME_BITS-1:0]           time_now_q, last_cmd_q, last_phase_q;
	logic [dpdt_pkg::ONTIME_W-1:0]  on_time_q;
	logic                           pump_on_q, stale_q;
	dpdt_pkg::health_level_t        level_q;
	dpdt_pkg::fault_code_t          code_q;

	// output register
	logic                    res_valid_q;
	logic                    res_drive_q;
	dpdt_pkg::health_level_t res_level_q;
	dpdt_pkg::fault_code_t   res_code_q;

	logic out_free, go_s1, take_req;
	logic [dpdt_pkg::PROD_W-1:0]   prod_full;
	logic [dpdt_pkg::ONTIME_W-1:0] on_time_cmd;

	logic [TIME_BITS-1:0]          time_nx, last_cmd_nx, last_phase_nx;
	logic [TIME_BITS-1:0]          since_cmd, since_phase;
	logic [dpdt_pkg::ONTIME_W-1:0] on_time_nx, off_time;
	logic                          pump_nx, stale_nx;
	dpdt_pkg::health_level_t       level_nx;
	dpdt_pkg::fault_code_t         code_nx;
	logic                          rate_below, rate_above;

	assign out_free  = !res_valid_q || res.ready;
	assign go_s1     = valid_s1 && out_free;
	assign req.ready = !valid_s1 || out_free;
	assign take_req  = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dosing_period_q    <= dpdt_pkg::PERIOD_RESET;
			shutoff_time_q     <= dpdt_pkg::SHUTOFF_RESET;
			drive_active_low_q <= 1'b0;
		end else if (cfg.valid) begin
			unique case (dpdt_pkg::cfg_idx_t'(cfg.index))
				dpdt_pkg::CFG_DOSING_PERIOD:
					dosing_period_q <= cfg.data[dpdt_pkg::PERIOD_W-1:0];
				dpdt_pkg::CFG_SHUTOFF_TIME:
					shutoff_time_q <= cfg.data[dpdt_pkg::SHUTOFF_W-1:0];
				dpdt_pkg::CFG_DRIVE_ACTIVE_LOW:
					drive_active_low_q <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// on-time product ahead of the input stage
	assign prod_full = dpdt_pkg::PROD_W'(req.rate_ml_per_hour) *
		dpdt_pkg::PROD_W'(dosing_period_q);

	// input stage: load on transfer, drain into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_req) begin
			kind_s1 <= dpdt_pkg::req_kind_t'(req.req_type);
			rate_s1 <= req.rate_ml_per_hour;
			prod_s1 <= prod_full;
		end
	end

	dpdt_ontime_div u_ontime_div (
		.product (prod_s1),
		.on_time (on_time_cmd)
	);

	// elapsed times against the advanced clock
	assign time_nx     = time_now_q + TIME_BITS'(1);
	assign since_cmd   = time_nx - last_cmd_q;
	assign since_phase = time_nx - last_phase_q;
	assign off_time    = (dosing_period_q > on_time_q) ? (dosing_period_q - on_time_q) :
		'0;
	assign rate_below  = (rate_s1 != '0) && (rate_s1 < dpdt_pkg::RATE_MIN);
	assign rate_above  = rate_s1 > dpdt_pkg::RATE_MAX;

	// next state for the item in the input stage
	always_comb begin
		last_cmd_nx   = last_cmd_q;
		last_phase_nx = last_phase_q;
		on_time_nx    = on_time_q;
		pump_nx       = pump_on_q;
		stale_nx      = stale_q;
		level_nx      = level_q;
		code_nx       = code_q;
		case (kind_s1)
			dpdt_pkg::REQ_TICK: begin
				if (!stale_q && (CMP_W'(since_cmd) > CMP_W'(shutoff_time_q))) begin
					// watchdog: stop and warn until a valid command
					pump_nx  = 1'b0;
					stale_nx = 1'b1;
					level_nx = dpdt_pkg::LVL_WARNING;
					code_nx  = dpdt_pkg::CODE_STALE;
				end else if (!stale_q) begin
					// end of the on or off phase; a fresh off phase cannot end the same tick
					if (pump_on_q && (since_phase > TIME_BITS'(on_time_q))) begin
						pump_nx       = 1'b0;
						last_phase_nx = time_nx;
					end else if (!pump_on_q && (since_phase > TIME_BITS'(off_time))) begin
						pump_nx       = 1'b1;
						last_phase_nx = time_nx;
					end
				end
			end
			default: begin
				if (rate_below) begin
					level_nx = dpdt_pkg::LVL_ERROR;
					code_nx  = dpdt_pkg::CODE_BELOW;
				end else if (rate_above) begin
					level_nx = dpdt_pkg::LVL_ERROR;
					code_nx  = dpdt_pkg::CODE_ABOVE;
				end else begin
					on_time_nx  = on_time_cmd;
					last_cmd_nx = time_now_q;
					stale_nx    = 1'b0;
					level_nx    = dpdt_pkg::LVL_OK;
					code_nx     = dpdt_pkg::CODE_OK;
				end
			end
		endcase
	end

	// commit state when the item leaves the input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_now_q   <= '0;
			last_cmd_q   <= '0;
			last_phase_q <= '0;
			on_time_q    <= '0;
			pump_on_q    <= 1'b0;
			stale_q      <= 1'b0;
			level_q      <= dpdt_pkg::LVL_OK;
			code_q       <= dpdt_pkg::CODE_OK;
		end else if (go_s1) begin
			if (kind_s1 == dpdt_pkg::REQ_TICK) begin
				time_now_q <= time_nx;
			end
			last_cmd_q   <= last_cmd_nx;
			last_phase_q <= last_phase_nx;
			on_time_q    <= on_time_nx;
			pump_on_q    <= pump_nx;
			stale_q      <= stale_nx;
			level_q      <= level_nx;
			code_q       <= code_nx;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			res_drive_q <= pump_nx ^ drive_active_low_q;
			res_level_q <= level_nx;
			res_code_q  <= code_nx;
		end
	end

	assign res.valid        = res_valid_q;
	assign res.drive_level  = res_drive_q;
	assign res.health_level = res_level_q;
	assign res.fault_code   = res_code_q;
endmodule

`default_nettype wire

// File: src/dpdt_ontime_div.sv
`default_nettype none

// Divide the rate * period product by 1000 with a reciprocal multiply.
module dpdt_ontime_div (
	input  wire logic [dpdt_pkg::PROD_W-1:0]   product,
	output logic      [dpdt_pkg::ONTIME_W-1:0] on_time
);
	localparam int Y_W   = dpdt_pkg::PROD_W - dpdt_pkg::PRE_SHIFT;
	localparam int MUL_W = Y_W + dpdt_pkg::RECIP_W;

	logic [Y_W-1:0]   y;
	logic [MUL_W-1:0] full;

	// drop the factor of eight first, then divide by 125
	assign y    = product[dpdt_pkg::PROD_W-1:dpdt_pkg::PRE_SHIFT];
	assign full = MUL_W'(y) * MUL_W'(dpdt_pkg::RECIP_M);
	assign on_time = full[dpdt_pkg::RECIP_SHIFT +: dpdt_pkg::ONTIME_W];
endmodule

`default_nettype wire

// File: src/dpdt_checker.sv
`default_nettype none

`include "dosing_pump_duty_timer_core_assert.svh"

module dpdt_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       req_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic       res_drive_level,
	input wire logic [1:0] res_health_level,
	input wire logic [1:0] res_fault_code
);
	// hold a stalled result
	`DPDT_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res_drive_level) && $stable(res_health_level) && $stable(res_fault_code))

	// level and code agree on ok and on warning
	`DPDT_ASSERT_SAME(a_status_pair, clk, arst_n, res_valid, ((res_health_level == dpdt_pkg::LVL_OK) == (res_fault_code == dpdt_pkg::CODE_OK)) && ((res_health_level == dpdt_pkg::LVL_WARNING) == (res_fault_code == dpdt_pkg::CODE_STALE)))

	// an error carries a rate code
	`DPDT_ASSERT_SAME(a_error_code, clk, arst_n, res_valid && (res_health_level == dpdt_pkg::LVL_ERROR), (res_fault_code == dpdt_pkg::CODE_BELOW) || (res_fault_code == dpdt_pkg::CODE_ABOVE))

	// an empty output register never blocks a request
	`DPDT_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !res_valid, req_ready)
endmodule

bind dosing_pump_duty_timer_core dpdt_checker u_dpdt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_ready        (req.ready),
	.res_valid        (res.valid),
	.res_ready        (res.ready),
	.res_drive_level  (res.drive_level),
	.res_health_level (res.health_level),
	.res_fault_code   (res.fault_code)
);

`default_nettype wire

// File: verif/dose_result_checker.sv
module dose_result_checker #(
	parameter int TIME_BITS = 32
) (
	input  logic clk,
	input  logic arst_n,
	dpdt_cfg_if  cfg,
	dpdt_req_if  req,
	dpdt_res_if  res,
	output int   fail_count,
	output int   pending_results
);
	import dpdt_pkg::*;

	typedef struct packed {
		logic          drive_level;
		health_level_t health_level;
		fault_code_t   fault_code;
	} pump_status_t;

	// Register copy
	logic [PERIOD_W-1:0]  period_ms;
	logic [SHUTOFF_W-1:0] shutoff_ms;
	logic                 invert_drive;

	// Timer and watchdog state
	logic [TIME_BITS-1:0] clock_ms;
	logic [TIME_BITS-1:0] cmd_stamp;
	logic [TIME_BITS-1:0] phase_stamp;
	logic [ONTIME_W-1:0]  on_ms;
	logic                 pump_running;
	logic                 watchdog_tripped;
	health_level_t        hold_level;
	fault_code_t          hold_code;

	pump_status_t expected_status_q[$];
	int           mismatches;
	int           outstanding;

	assign fail_count      = mismatches;
	assign pending_results = outstanding;

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Advance the millisecond clock, then the watchdog, then the on/off phases
	function automatic void run_tick();
		logic [TIME_BITS-1:0] gap;
		logic [ONTIME_W-1:0]  off_ms;
		clock_ms = clock_ms + 1'b1;
		gap = clock_ms - cmd_stamp;
		if (!watchdog_tripped && gap > shutoff_ms) begin
			pump_running     = 1'b0;
			watchdog_tripped = 1'b1;
			hold_level       = LVL_WARNING;
			hold_code        = CODE_STALE;
		end else if (!watchdog_tripped) begin
			// off time saturates when the period dropped under the on time
			off_ms = (period_ms > on_ms) ? period_ms - on_ms : '0;
			gap = clock_ms - phase_stamp;
			if (pump_running && gap > on_ms) begin
				pump_running = 1'b0;
				phase_stamp  = clock_ms;
			end
			gap = clock_ms - phase_stamp;
			if (!pump_running && gap > off_ms) begin
				pump_running = 1'b1;
				phase_stamp  = clock_ms;
			end
		end
	endfunction

	// Reject out-of-range rates, otherwise take the new on time and rearm
	function automatic void run_command(input logic [RATE_W-1:0] rate);
		logic [31:0] product;
		if (rate != '0 && rate < RATE_MIN) begin
			hold_level = LVL_ERROR;
			hold_code  = CODE_BELOW;
		end else if (rate > RATE_MAX) begin
			hold_level = LVL_ERROR;
			hold_code  = CODE_ABOVE;
		end else begin
			product          = 32'(rate) * 32'(period_ms);
			on_ms            = ONTIME_W'(product / 32'(RATE_MAX));
			cmd_stamp        = clock_ms;
			watchdog_tripped = 1'b0;
			hold_level       = LVL_OK;
			hold_code        = CODE_OK;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pump_status_t want;
		if (!arst_n) begin
			period_ms        = PERIOD_RESET;
			shutoff_ms       = SHUTOFF_RESET;
			invert_drive     = 1'b0;
			clock_ms         = '0;
			cmd_stamp        = '0;
			phase_stamp      = '0;
			on_ms            = '0;
			pump_running     = 1'b0;
			watchdog_tripped = 1'b0;
			hold_level       = LVL_OK;
			hold_code        = CODE_OK;
			expected_status_q.delete();
			mismatches       = 0;
		end else begin
			// Track register writes
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_DOSING_PERIOD:    period_ms    = cfg.data[PERIOD_W-1:0];
					CFG_SHUTOFF_TIME:     shutoff_ms   = cfg.data[SHUTOFF_W-1:0];
					CFG_DRIVE_ACTIVE_LOW: invert_drive = cfg.data[0];
					default: ;
				endcase
			end

			// Predict the status after each request transfer
			if (req.valid && req.ready) begin
				if (req.req_type == REQ_TICK)
					run_tick();
				else
					run_command(req.rate_ml_per_hour);
				want.drive_level  = pump_running ^ invert_drive;
				want.health_level = hold_level;
				want.fault_code   = hold_code;
				expected_status_q.push_back(want);
			end

			// Compare each result transfer with the oldest prediction
			if (res.valid && res.ready) begin
				if (expected_status_q.size() == 0) begin
					report_mismatch("result with nothing expected");
				end else begin
					want = expected_status_q.pop_front();
					if (res.drive_level !== want.drive_level)
						report_mismatch($sformatf("drive_level got %b want %b",
							res.drive_level, want.drive_level));
					if (res.health_level !== want.health_level)
						report_mismatch($sformatf("health_level got %0d want %0d",
							res.health_level, want.health_level));
					if (res.fault_code !== want.fault_code)
						report_mismatch($sformatf("fault_code got %0d want %0d",
							res.fault_code, want.fault_code));
				end
			end
		end
		outstanding <= expected_status_q.size();
	end

endmodule

// File: verif/tb_top.sv
module tb_top;
	import dpdt_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 11;
	localparam int IDLE_PCT        = 21;
	localparam int HOLD_CYCLES     = 64;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 150;
	localparam int DRAIN_CYCLES    = 8;
	localparam int LIMIT_CYCLES    = 400000;

	// Index past the register list, written once to show it is ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 2'd3;

	logic clk;
	logic arst_n;
	logic calm;       // no idling on either side
	logic take_hold;  // ask the result side for one long hold-off
	int   fail_count;
	int   pending_results;

	dpdt_cfg_if cfg_ch();
	dpdt_req_if req_ch();
	dpdt_res_if res_ch();

	dosing_pump_duty_timer_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.res    (res_ch)
	);

	dose_result_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_ch),
		.req             (req_ch),
		.res             (res_ch),
		.fail_count      (fail_count),
		.pending_results (pending_results)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Give up on a hung run
	initial begin
		#(LIMIT_CYCLES * 2 * CLK_HALF);
		$display("FAIL dosing_pump_duty_timer_core");
		$finish;
	end

	// Result side: random stalls, one long hold-off on request
	initial begin : result_sink
		int hold_left;
		hold_left = 0;
		res_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				res_ch.ready <= 1'b0;
				hold_left--;
			end else if (take_hold) begin
				take_hold = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				res_ch.ready <= 1'b0;
			end else if (calm) begin
				res_ch.ready <= 1'b1;
			end else begin
				res_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	// Offer one request, with a random gap first, and hold it until the transfer
	task automatic send_req(input req_kind_t kind, input logic [RATE_W-1:0] rate);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid            <= 1'b1;
		req_ch.req_type         <= kind;
		req_ch.rate_ml_per_hour <= rate;
		do begin
			@(posedge clk);
		end while (!req_ch.ready);
	endtask

	// Start one register write and wait for its transfer; caller drops valid
	task automatic put_reg(input logic [CFG_IDX_W-1:0] index,
		input logic [CFG_DATA_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ch.ready);
	endtask

	task automatic set_timing(input logic [PERIOD_W-1:0] period,
		input logic [SHUTOFF_W-1:0] shutoff, input logic invert);
		put_reg(CFG_DOSING_PERIOD, 32'(period));
		put_reg(CFG_SHUTOFF_TIME, shutoff);
		put_reg(CFG_DRIVE_ACTIVE_LOW, 32'(invert));
		cfg_ch.valid <= 1'b0;
	endtask

	// Stop offering and wait until every predicted status has come back
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Mostly valid rates, some too low or too high, a few zero
	function automatic logic [RATE_W-1:0] pick_rate();
		int roll;
		roll = $urandom_range(99);
		if (roll < 5)
			return '0;
		if (roll < 70)
			return RATE_W'($urandom_range(1000, 100));
		if (roll < 85)
			return RATE_W'($urandom_range(99, 1));
		return RATE_W'($urandom_range(65535, 1001));
	endfunction

	// Tick stream with commands sprinkled in to keep the watchdog fed
	task automatic run_random(input int count);
		repeat (count) begin
			if ($urandom_range(99) < 18)
				send_req(REQ_COMMAND, pick_rate());
			else
				send_req(REQ_TICK, RATE_W'($urandom));
		end
	endtask

	initial begin : stimulus
		arst_n                  = 1'b0;
		calm                    = 1'b0;
		take_hold               = 1'b0;
		cfg_ch.valid            = 1'b0;
		cfg_ch.index            = '0;
		cfg_ch.data             = '0;
		req_ch.valid            = 1'b0;
		req_ch.req_type         = REQ_TICK;
		req_ch.rate_ml_per_hour = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings, no command yet: zero on time
		repeat (2) send_req(REQ_TICK, '0);
		drain_results();

		// Short period and watchdog so every path shows up in a few items
		set_timing(16'd4, 32'd6, 1'b0);
		repeat (3) send_req(REQ_TICK, 16'hFFFF);
		send_req(REQ_COMMAND, 16'd1);
		send_req(REQ_COMMAND, 16'd99);
		send_req(REQ_COMMAND, 16'd1001);
		send_req(REQ_COMMAND, 16'hFFFF);
		send_req(REQ_COMMAND, RATE_MIN);
		send_req(REQ_COMMAND, RATE_MAX);
		// Let the watchdog trip, then tick once more while stale
		repeat (8) send_req(REQ_TICK, '0);
		// Zero rate is valid and rearms; then fill the whole period
		send_req(REQ_COMMAND, '0);
		send_req(REQ_COMMAND, RATE_MAX);
		repeat (2) send_req(REQ_TICK, '0);
		drain_results();

		// Drop the period under the on time: off time saturates at zero
		put_reg(CFG_DOSING_PERIOD, 32'd1);
		put_reg(CFG_SPARE_IDX, 32'hFFFF_FFFF);
		cfg_ch.valid <= 1'b0;
		repeat (4) send_req(REQ_TICK, '0);
		drain_results();

		// Random phases over several settings, fixed ones including the extremes first
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: set_timing(16'd20, 32'd50, 1'b0);
				1: set_timing(16'd1, 32'd1, 1'b1);
				2: set_timing(16'hFFFF, 32'hFFFF_FFFF, 1'b0);
				3: set_timing(16'd7, 32'd30, 1'b1);
				default: set_timing(PERIOD_W'($urandom_range(60, 1)),
					SHUTOFF_W'($urandom_range(150, 1)), 1'($urandom_range(1)));
			endcase
			calm = (phase == 3);
			if (phase == 4)
				take_hold = 1'b1;
			run_random(ITEMS_PER_PHASE);
			drain_results();
		end

		if (fail_count == 0 && pending_results == 0)
			$display("PASS dosing_pump_duty_timer_core");
		else
			$display("FAIL dosing_pump_duty_timer_core");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/dpdt_pkg.sv
src/dpdt_cfg_if.sv
src/dpdt_req_if.sv
src/dpdt_res_if.sv
src/dpdt_ontime_div.sv
src/dosing_pump_duty_timer_core.sv
src/dpdt_checker.sv
verif/dose_result_checker.sv
verif/tb_top.sv
